// ===== rtl/wdos_pkg.sv =====
// Package for the window depth order stack.
// Request modes, result status codes and the result record; no dependencies.
package wdos_pkg;

  localparam int ModeW   = 3;
  localparam int IdW     = 8;
  localparam int StatusW = 3;
  localparam int CountW  = 6;

  localparam logic [ModeW-1:0] MODE_ADD   = 3'd0;
  localparam logic [ModeW-1:0] MODE_REM   = 3'd1;
  localparam logic [ModeW-1:0] MODE_RAISE = 3'd2;
  localparam logic [ModeW-1:0] MODE_LOWER = 3'd3;
  localparam logic [ModeW-1:0] MODE_TOP   = 3'd4;
  localparam logic [ModeW-1:0] MODE_BELOW = 3'd5;
  localparam logic [ModeW-1:0] MODE_CLEAR = 3'd6;

  localparam logic [StatusW-1:0] ST_OK     = 3'd0;
  localparam logic [StatusW-1:0] ST_NULL   = 3'd1;
  localparam logic [StatusW-1:0] ST_DUP    = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL   = 3'd3;
  localparam logic [StatusW-1:0] ST_ABSENT = 3'd4;

  localparam logic [IdW-1:0] ID_NONE = 8'd0;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     answer_id;
    logic [CountW-1:0]  window_count;
  } res_t;

endpackage

// ===== rtl/wdos_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on wdos_pkg for field widths.
interface wdos_req_if import wdos_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ModeW-1:0] mode;
  logic [IdW-1:0]   window_id;
  modport source (output valid, mode, window_id, input ready);
  modport sink   (input valid, mode, window_id, output ready);
endinterface

interface wdos_rsp_if import wdos_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     answer_id;
  logic [CountW-1:0]  window_count;
  modport source (output valid, status, answer_id, window_count, input ready);
  modport sink   (input valid, status, answer_id, window_count, output ready);
endinterface

// ===== rtl/window_depth_order_stack.sv =====
// Window depth order stack: keeps up to MAX_WINDOWS window ids front to back in one
// synchronous memory and serves one request at a time. A request walks the memory one
// entry at a time to find its id (read, then compare), then shifts entries one at a time
// (neighbour read, then write). The worst case is raising the bottom of a full order.
// Every step goes through the one registered read port and the one write port of the
// order memory. The result sits in an output register, so a new request is taken while
// the previous result waits.
module window_depth_order_stack import wdos_pkg::*; #(
  parameter int MAX_WINDOWS = 32
) (
  input logic       clk,
  input logic       rst_n,
  wdos_req_if.sink  in_req,
  wdos_rsp_if.source out_rsp
);

  logic seq_valid;
  logic seq_ready;
  res_t seq_res;
  logic out_valid_r;
  res_t out_res_r;

  wdos_seq #(.MAX_WINDOWS(MAX_WINDOWS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .req_mode  (in_req.mode),
    .req_id    (in_req.window_id),
    .res_valid (seq_valid),
    .res_ready (seq_ready),
    .res       (seq_res)
  );

  // Output register: load when empty or being drained
  assign seq_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_ready) begin
      out_valid_r <= seq_valid;
    end
    if (seq_ready && seq_valid) begin
      out_res_r <= seq_res;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_res_r.status;
  assign out_rsp.answer_id    = out_res_r.answer_id;
  assign out_rsp.window_count = out_res_r.window_count;

endmodule

// ===== rtl/wdos_seq.sv =====
// Sequencer and order memory: searches, shifts and rewrites entries one per step.
// Depends on wdos_pkg.
module wdos_seq import wdos_pkg::*; #(
  parameter int MAX_WINDOWS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [ModeW-1:0] req_mode,
  input  logic [IdW-1:0]   req_id,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CW = $clog2(MAX_WINDOWS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_WINDOWS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_MWR  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_QRD  = 4'd6;
  localparam logic [3:0] S_QANS = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [IdW-1:0] mem [MAX_WINDOWS];
  logic [IdW-1:0] rdata_r;

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      qaddr_r, qaddr_nxt;
  logic [ModeW-1:0]   mode_r, mode_nxt;
  logic [IdW-1:0]     id_r, id_nxt;
  logic [StatusW-1:0] st_r, st_nxt;
  logic [IdW-1:0]     ans_r, ans_nxt;
  logic               up_r, up_nxt;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [IdW-1:0] wdata;
  logic [AW-1:0]  raddr;
  logic [CW-1:0]  idx_ext;
  logic           is_keyed;

  assign idx_ext  = CW'(idx_r);
  assign is_keyed = (req_mode inside {MODE_ADD, MODE_REM, MODE_RAISE, MODE_LOWER, MODE_BELOW});

  // Read port address per state
  always_comb begin
    case (state_r)
      S_SRD:   raddr = idx_r;
      S_MRD:   raddr = up_r ? AW'(idx_ext + 1'b1) : AW'(idx_ext - 1'b1);
      S_QRD:   raddr = qaddr_r;
      default: raddr = '0;
    endcase
  end

  // Order memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    qaddr_nxt = qaddr_r;
    mode_nxt  = mode_r;
    id_nxt    = id_r;
    st_nxt    = st_r;
    ans_nxt   = ans_r;
    up_nxt    = up_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = rdata_r;
    case (state_r)
      // Take a request and decide its path
      S_IDLE: begin
        if (req_valid) begin
          mode_nxt = req_mode;
          id_nxt   = req_id;
          st_nxt   = ST_OK;
          ans_nxt  = ID_NONE;
          idx_nxt  = '0;
          if (is_keyed && req_id == ID_NONE) begin
            st_nxt    = ST_NULL;
            state_nxt = S_DONE;
          end else if (is_keyed) begin
            if (cnt_r == '0) begin
              if (req_mode == MODE_ADD) begin
                up_nxt    = 1'b0;
                state_nxt = S_MRD;
              end else begin
                st_nxt    = ST_ABSENT;
                state_nxt = S_DONE;
              end
            end else begin
              state_nxt = S_SRD;
            end
          end else if (req_mode == MODE_TOP) begin
            qaddr_nxt = '0;
            state_nxt = (cnt_r == '0) ? S_DONE : S_QRD;
          end else if (req_mode == MODE_CLEAR) begin
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SRD: state_nxt = S_SCMP;
      // Compare one entry against the id
      S_SCMP: begin
        if (rdata_r == id_r) begin
          case (mode_r)
            MODE_ADD: begin
              st_nxt    = ST_DUP;
              state_nxt = S_DONE;
            end
            MODE_BELOW: begin
              if (idx_ext + 1'b1 < cnt_r) begin
                qaddr_nxt = AW'(idx_ext + 1'b1);
                state_nxt = S_QRD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            MODE_RAISE: begin
              up_nxt    = 1'b0;
              state_nxt = S_MRD;
            end
            default: begin
              up_nxt    = 1'b1;
              state_nxt = S_MRD;
            end
          endcase
        end else if (idx_ext + 1'b1 < cnt_r) begin
          idx_nxt   = AW'(idx_ext + 1'b1);
          state_nxt = S_SRD;
        end else if (mode_r == MODE_ADD) begin
          if (cnt_r >= MaxCnt) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = AW'(cnt_r);
            up_nxt    = 1'b0;
            state_nxt = S_MRD;
          end
        end else begin
          st_nxt    = ST_ABSENT;
          state_nxt = S_DONE;
        end
      end
      // Issue the neighbour read, or stop at the end of the run
      S_MRD: begin
        if (up_r ? (idx_ext + 1'b1 < cnt_r) : (idx_r != '0)) begin
          state_nxt = S_MWR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      // Move the neighbour into the current slot and advance
      S_MWR: begin
        we        = 1'b1;
        waddr     = idx_r;
        wdata     = rdata_r;
        idx_nxt   = up_r ? AW'(idx_ext + 1'b1) : AW'(idx_ext - 1'b1);
        state_nxt = S_MRD;
      end
      // Place the id and settle the count
      S_FIN: begin
        wdata = id_r;
        case (mode_r)
          MODE_ADD: begin
            we      = 1'b1;
            waddr   = '0;
            cnt_nxt = cnt_r + 1'b1;
          end
          MODE_RAISE: begin
            we    = 1'b1;
            waddr = '0;
          end
          MODE_LOWER: begin
            we    = 1'b1;
            waddr = AW'(cnt_r - 1'b1);
          end
          default: cnt_nxt = cnt_r - 1'b1;
        endcase
        state_nxt = S_DONE;
      end
      S_QRD: state_nxt = S_QANS;
      S_QANS: begin
        ans_nxt   = rdata_r;
        state_nxt = S_DONE;
      end
      // Hold the result until taken
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r   <= idx_nxt;
    qaddr_r <= qaddr_nxt;
    mode_r  <= mode_nxt;
    id_r    <= id_nxt;
    st_r    <= st_nxt;
    ans_r   <= ans_nxt;
    up_r    <= up_nxt;
  end

  assign req_ready        = (state_r == S_IDLE);
  assign res_valid        = (state_r == S_DONE);
  assign res.status       = st_r;
  assign res.answer_id    = ans_r;
  assign res.window_count = CountW'(cnt_r);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MaxCnt)
    else $error("window count above capacity");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($past(state_r) == S_FIN || $past(state_r) == S_IDLE))
    else $error("window count changed outside finish or clear");
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR) |-> (idx_ext < cnt_r || (mode_r == MODE_ADD && idx_ext == cnt_r)))
    else $error("shift write outside the order");
  a_done_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && mode_r == MODE_ADD) |-> (cnt_r < MaxCnt))
    else $error("add completing on a full order");

endmodule
